// File: design/gdsc_pkg.sv
`default_nettype none

package gdsc_pkg;

    localparam int SERIAL_W = 22;
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int N_W      = 14;
    localparam int DOY_W    = 9;
    localparam int D_W      = SERIAL_W + 1;
    localparam int Q_W      = 8;
    localparam int CORR_W   = N_W - 2;
    localparam int MUL_A_W  = 22;
    localparam int MUL_B_W  = 23;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    localparam logic KIND_ENCODE = 1'b0;
    localparam logic KIND_DECODE = 1'b1;

    localparam logic [YEAR_W-1:0]  BASE_YEAR = 14'd1601;
    localparam logic [YEAR_W-1:0]  MAX_YEAR  = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTHS    = 4'd12;
    localparam logic [MONTH_W-1:0] FEBRUARY  = 4'd2;

    // floor(x / 100) = (x * RECIP100) >> 19 for x < 43690
    localparam logic [MUL_B_W-1:0] RECIP100       = 23'd5243;
    localparam int                 RECIP100_SHIFT = 19;
    // floor(x / 365) = (x * RECIP365) >> 31 for every 22-bit x
    localparam logic [MUL_B_W-1:0] RECIP365       = 23'd5883517;
    localparam int                 RECIP365_SHIFT = 31;
    localparam logic [MUL_B_W-1:0] DAYS_PER_YEAR  = 23'd365;

    typedef struct packed {
        logic                kind;
        logic [DAY_W-1:0]    in_day;
        logic [MONTH_W-1:0]  in_month;
        logic [YEAR_W-1:0]   in_year;
        logic [SERIAL_W-1:0] in_serial;
    } req_item_t;

    typedef struct packed {
        logic [SERIAL_W-1:0] out_serial;
        logic [DAY_W-1:0]    out_day;
        logic [MONTH_W-1:0]  out_month;
        logic [YEAR_W-1:0]   out_year;
    } rsp_item_t;

    typedef struct packed {
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic      valid;
        rsp_item_t item;
    } push_t;

    // days before the first of the month
    function automatic logic [DOY_W-1:0] cum_days(input logic leap,
                                                  input logic [MONTH_W-1:0] month);
        logic [DOY_W-1:0] v;
        case (month)
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd0;
        endcase
        if (leap && (month > FEBRUARY) && (month <= MONTHS))
        begin
            v = v + 9'd1;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: design/gdsc_mul.sv
`default_nettype none

module gdsc_mul (
    input  wire logic                          clk,
    input  wire gdsc_pkg::mul_req_t            req,
    output logic [gdsc_pkg::PROD_W-1:0]        prod
);

    logic [gdsc_pkg::PROD_W-1:0] prod_reg;
    logic [gdsc_pkg::PROD_W-1:0] prod_next;

    assign prod_next = gdsc_pkg::PROD_W'(req.a) * gdsc_pkg::PROD_W'(req.b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// File: design/gdsc_ctrl.sv
`default_nettype none

module gdsc_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire gdsc_pkg::req_item_t           req_item,
    output logic                               busy,
    output gdsc_pkg::mul_req_t                 mul_req,
    input  wire logic [gdsc_pkg::PROD_W-1:0]   prod,
    output gdsc_pkg::push_t                    push,
    input  wire logic                          push_ready
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EST  = 4'd1;
    localparam logic [3:0] S_ESTN = 4'd2;
    localparam logic [3:0] S_Q100 = 4'd3;
    localparam logic [3:0] S_M365 = 4'd4;
    localparam logic [3:0] S_DSUM = 4'd5;
    localparam logic [3:0] S_QY   = 4'd6;
    localparam logic [3:0] S_LEAP = 4'd7;
    localparam logic [3:0] S_MON  = 4'd8;
    localparam logic [3:0] S_PUSH = 4'd9;

    logic [3:0] state_reg, state_next;

    logic                                kind_reg, kind_next;
    logic [gdsc_pkg::SERIAL_W-1:0]       serial_reg, serial_next;
    logic [gdsc_pkg::DAY_W-1:0]          day_reg, day_next;
    logic [gdsc_pkg::MONTH_W-1:0]        month_reg, month_next;
    logic [gdsc_pkg::N_W-1:0]            n_reg, n_next;
    logic [gdsc_pkg::CORR_W-1:0]         corr_reg, corr_next;
    logic [gdsc_pkg::D_W-1:0]            d_reg, d_next;
    logic [gdsc_pkg::DOY_W-1:0]          doy_reg, doy_next;
    logic                                leap_reg, leap_next;
    logic [gdsc_pkg::MONTH_W-1:0]        m_reg, m_next;
    gdsc_pkg::rsp_item_t                 res_reg, res_next;

    logic [gdsc_pkg::Q_W-1:0]            q_prod;
    logic [gdsc_pkg::N_W-1:0]            n_est;
    logic [gdsc_pkg::YEAR_W-1:0]         year_cur;
    logic [gdsc_pkg::CORR_W-1:0]         corr_now;
    logic [gdsc_pkg::D_W-1:0]            d_sum;
    logic [gdsc_pkg::YEAR_W:0]           q_x100;
    logic                                leap_now;
    logic [gdsc_pkg::D_W-1:0]            enc_sum;
    logic [gdsc_pkg::D_W-1:0]            doy_full;
    logic [gdsc_pkg::DOY_W-1:0]          tab_m;
    logic [gdsc_pkg::MONTH_W-1:0]        m_dec;
    logic [gdsc_pkg::DOY_W-1:0]          day_full;
    logic                                enc_ok;

    assign q_prod   = prod[gdsc_pkg::RECIP100_SHIFT +: gdsc_pkg::Q_W];
    assign n_est    = prod[gdsc_pkg::RECIP365_SHIFT +: gdsc_pkg::N_W];
    assign year_cur = n_reg + gdsc_pkg::BASE_YEAR;

    // n/4 - n/100 + n/400, never negative
    assign corr_now = n_reg[gdsc_pkg::N_W-1:2]
                    + gdsc_pkg::CORR_W'(q_prod[gdsc_pkg::Q_W-1:2])
                    - gdsc_pkg::CORR_W'(q_prod);
    assign d_sum    = {1'b0, prod[gdsc_pkg::SERIAL_W-1:0]} + gdsc_pkg::D_W'(corr_reg);

    assign q_x100   = (gdsc_pkg::YEAR_W+1)'(q_prod) * 15'd100;
    assign leap_now = (year_cur[1:0] == 2'd0)
                   && ((q_x100 != {1'b0, year_cur}) || (q_prod[1:0] == 2'd0));

    assign enc_sum  = d_reg + gdsc_pkg::D_W'(gdsc_pkg::cum_days(leap_now, month_reg))
                    + gdsc_pkg::D_W'(day_reg);
    assign doy_full = {1'b0, serial_reg} - d_reg;

    assign tab_m    = gdsc_pkg::cum_days(leap_reg, m_reg);
    assign m_dec    = m_reg - 4'd1;
    assign day_full = doy_reg - gdsc_pkg::cum_days(leap_reg, m_dec);

    assign enc_ok   = (req_item.in_year >= gdsc_pkg::BASE_YEAR)
                   && (req_item.in_year <= gdsc_pkg::MAX_YEAR)
                   && (req_item.in_month >= 4'd1)
                   && (req_item.in_month <= gdsc_pkg::MONTHS);

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        serial_next = serial_reg;
        day_next    = day_reg;
        month_next  = month_reg;
        n_next      = n_reg;
        corr_next   = corr_reg;
        d_next      = d_reg;
        doy_next    = doy_reg;
        leap_next   = leap_reg;
        m_next      = m_reg;
        res_next    = res_reg;
        mul_req.a   = '0;
        mul_req.b   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next   = req_item.kind;
                    serial_next = req_item.in_serial;
                    day_next    = req_item.in_day;
                    month_next  = req_item.in_month;
                    n_next      = req_item.in_year - gdsc_pkg::BASE_YEAR;
                    res_next    = '0;
                    if (req_item.kind == gdsc_pkg::KIND_ENCODE)
                    begin
                        state_next = enc_ok ? S_Q100 : S_PUSH;
                    end
                    else
                    begin
                        res_next.out_serial = req_item.in_serial;
                        state_next = (req_item.in_serial == '0) ? S_PUSH : S_EST;
                    end
                end
            end
            S_EST:
            begin
                mul_req.a  = serial_reg;
                mul_req.b  = gdsc_pkg::RECIP365;
                state_next = S_ESTN;
            end
            S_ESTN:
            begin
                n_next     = n_est;
                state_next = S_Q100;
            end
            S_Q100:
            begin
                mul_req.a  = gdsc_pkg::MUL_A_W'(n_reg);
                mul_req.b  = gdsc_pkg::RECIP100;
                state_next = S_M365;
            end
            S_M365:
            begin
                corr_next  = corr_now;
                mul_req.a  = gdsc_pkg::MUL_A_W'(n_reg);
                mul_req.b  = gdsc_pkg::DAYS_PER_YEAR;
                state_next = S_DSUM;
            end
            S_DSUM:
            begin
                d_next    = d_sum;
                // start n-1 / 100 early in case another step down follows
                mul_req.a = gdsc_pkg::MUL_A_W'(n_reg - 14'd1);
                mul_req.b = gdsc_pkg::RECIP100;
                if ((kind_reg == gdsc_pkg::KIND_DECODE)
                    && (d_sum >= {1'b0, serial_reg}) && (n_reg != '0))
                begin
                    n_next     = n_reg - 14'd1;
                    state_next = S_M365;
                end
                else
                begin
                    state_next = S_QY;
                end
            end
            S_QY:
            begin
                mul_req.a  = gdsc_pkg::MUL_A_W'(year_cur);
                mul_req.b  = gdsc_pkg::RECIP100;
                state_next = S_LEAP;
            end
            S_LEAP:
            begin
                leap_next = leap_now;
                if (kind_reg == gdsc_pkg::KIND_ENCODE)
                begin
                    res_next.out_serial = enc_sum[gdsc_pkg::SERIAL_W-1:0];
                    state_next = S_PUSH;
                end
                else
                begin
                    doy_next   = doy_full[gdsc_pkg::DOY_W-1:0];
                    m_next     = gdsc_pkg::FEBRUARY;
                    state_next = S_MON;
                end
            end
            S_MON:
            begin
                if ((m_reg <= gdsc_pkg::MONTHS) && (doy_reg > tab_m))
                begin
                    m_next = m_reg + 4'd1;
                end
                else
                begin
                    res_next.out_day   = day_full[gdsc_pkg::DAY_W-1:0];
                    res_next.out_month = m_dec;
                    res_next.out_year  = year_cur;
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        serial_reg <= serial_next;
        day_reg    <= day_next;
        month_reg  <= month_next;
        n_reg      <= n_next;
        corr_reg   <= corr_next;
        d_reg      <= d_next;
        doy_reg    <= doy_next;
        leap_reg   <= leap_next;
        m_reg      <= m_next;
        res_reg    <= res_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign push.valid = (state_reg == S_PUSH);
    assign push.item  = res_reg;

endmodule

`default_nettype wire

// File: design/gregorian_date_serial_converter.sv
// Steps: encode Q100, M365, DSUM, QY, LEAP, PUSH (only PUSH for an out-of-range year or month);
// decode adds EST, ESTN first, repeats M365/DSUM per year step-down after the serial/365
// estimate and steps MON up to the decoded month; serial zero goes straight to PUSH.
// Throughput: one item at a time; the next is taken once the result has left the sequencer.
// All steps share one registered 22x23 multiplier.
// Reset: rst_n asynchronous active low; clears sequencer and output valid.
`default_nettype none

module gregorian_date_serial_converter (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output logic                        req_stall,
    input  wire gdsc_pkg::req_item_t    req_item,
    output logic                        rsp_valid,
    input  wire logic                   rsp_stall,
    output gdsc_pkg::rsp_item_t         rsp_item
);

    gdsc_pkg::mul_req_t             mul_req;
    logic [gdsc_pkg::PROD_W-1:0]    prod;
    gdsc_pkg::push_t                push;
    logic                           busy;
    logic                           start;
    logic                           rsp_free;

    logic                           rsp_valid_reg, rsp_valid_next;
    gdsc_pkg::rsp_item_t            rsp_item_reg, rsp_item_next;

    assign start    = req_valid && !busy;
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    gdsc_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    gdsc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .req_item   (req_item),
        .busy       (busy),
        .mul_req    (mul_req),
        .prod       (prod),
        .push       (push),
        .push_ready (rsp_free)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_item_next  = rsp_item_reg;
        if (rsp_free)
        begin
            rsp_valid_next = push.valid;
            if (push.valid)
            begin
                rsp_item_next = push.item;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_item_reg <= rsp_item_next;
    end

    assign req_stall = busy;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("sequencer not busy after accepting an item");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_item.out_month <= gdsc_pkg::MONTHS))
        else $error("decoded month out of range");

    a_decode_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_item.out_month != '0)) |->
            ((rsp_item.out_day != '0) && (rsp_item.out_year >= gdsc_pkg::BASE_YEAR)))
        else $error("decoded date has zero day or year below base");

    a_encode_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_item.out_month == '0)) |->
            ((rsp_item.out_day == '0) && (rsp_item.out_year == '0)))
        else $error("result without month carries day or year");
`endif

endmodule

`default_nettype wire

// File: dv/gregorian_date_serial_converter_tb.sv
`timescale 1ns / 100ps

module gregorian_date_serial_converter_tb;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned LAST_SERIAL = 3067671;
    localparam int unsigned MONTH_START [13] =
        '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    typedef struct {
        gdsc_pkg::req_item_t item;
        int unsigned         gap;
        bit                  hold;
    } pending_req_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    gdsc_pkg::req_item_t req_item = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    gdsc_pkg::rsp_item_t rsp_item;

    pending_req_t        pending_reqs [$];
    gdsc_pkg::rsp_item_t expected_rsps [$];
    int unsigned         send_gap;
    bit                  sending;
    int unsigned         stall_left;
    int unsigned         rsp_count;
    int unsigned         error_count;
    int unsigned         cycle_count;

    gregorian_date_serial_converter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic bit is_leap_year(int unsigned yr);
        return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
    endfunction

    // days in n whole years counted from the first day of the base year
    function automatic int unsigned days_in_years(int unsigned n);
        return n * 365 + n / 4 - n / 100 + n / 400;
    endfunction

    function automatic int unsigned days_before_month(bit leap, int unsigned mon);
        return MONTH_START[mon] + ((leap && mon > gdsc_pkg::FEBRUARY) ? 1 : 0);
    endfunction

    function automatic gdsc_pkg::rsp_item_t predict_conversion(gdsc_pkg::req_item_t item);
        int unsigned         yr;
        int unsigned         mon;
        int unsigned         n;
        int unsigned         d;
        int unsigned         doy;
        int unsigned         s;
        bit                  leap;
        gdsc_pkg::rsp_item_t res;
        res = '0;
        if (item.kind == gdsc_pkg::KIND_ENCODE)
        begin
            yr = item.in_year;
            mon = item.in_month;
            if (yr >= gdsc_pkg::BASE_YEAR && yr <= gdsc_pkg::MAX_YEAR
                && mon >= 1 && mon <= gdsc_pkg::MONTHS)
            begin
                s = days_in_years(yr - gdsc_pkg::BASE_YEAR)
                    + days_before_month(is_leap_year(yr), mon) + item.in_day;
                res.out_serial = gdsc_pkg::SERIAL_W'(s);
            end
        end
        else
        begin
            s = item.in_serial;
            res.out_serial = item.in_serial;
            if (s != 0)
            begin
                n = s / 365;
                d = days_in_years(n);
                while (d >= s && n > 0)
                begin
                    n--;
                    d = days_in_years(n);
                end
                yr = gdsc_pkg::BASE_YEAR + n;
                doy = s - d;
                leap = is_leap_year(yr);
                mon = gdsc_pkg::FEBRUARY;
                while (mon <= gdsc_pkg::MONTHS && doy > days_before_month(leap, mon))
                begin
                    mon++;
                end
                mon--;
                res.out_day = gdsc_pkg::DAY_W'(doy - days_before_month(leap, mon));
                res.out_month = gdsc_pkg::MONTH_W'(mon);
                res.out_year = gdsc_pkg::YEAR_W'(yr);
            end
        end
        return res;
    endfunction

    function automatic gdsc_pkg::req_item_t encode_req(int unsigned day, int unsigned mon,
                                                       int unsigned yr);
        gdsc_pkg::req_item_t it;
        it.kind = gdsc_pkg::KIND_ENCODE;
        it.in_day = gdsc_pkg::DAY_W'(day);
        it.in_month = gdsc_pkg::MONTH_W'(mon);
        it.in_year = gdsc_pkg::YEAR_W'(yr);
        it.in_serial = gdsc_pkg::SERIAL_W'($urandom);
        return it;
    endfunction

    function automatic gdsc_pkg::req_item_t decode_req(int unsigned serial);
        gdsc_pkg::req_item_t it;
        it.kind = gdsc_pkg::KIND_DECODE;
        it.in_day = gdsc_pkg::DAY_W'($urandom);
        it.in_month = gdsc_pkg::MONTH_W'($urandom);
        it.in_year = gdsc_pkg::YEAR_W'($urandom);
        it.in_serial = gdsc_pkg::SERIAL_W'(serial);
        return it;
    endfunction

    function automatic int unsigned serial_of(int unsigned day, int unsigned mon,
                                              int unsigned yr);
        gdsc_pkg::rsp_item_t r;
        r = predict_conversion(encode_req(day, mon, yr));
        return r.out_serial;
    endfunction

    task automatic queue_item(gdsc_pkg::req_item_t it, bit hold);
        pending_req_t p;
        p.item = it;
        p.hold = hold;
        // every fourth stretch of 50 items goes back to back
        p.gap = ((pending_reqs.size() / 50) % 4 == 3) ? 0 : $urandom_range(0, 7);
        pending_reqs.push_back(p);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_item <= '0;
            send_gap = 0;
        end
        else
        begin
            sending = req_valid;
            if (req_valid && !req_stall)
            begin
                expected_rsps.push_back(predict_conversion(req_item));
                sending = 1'b0;
            end
            if (!sending)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0
                         && (!pending_reqs[0].hold || expected_rsps.size() == 0))
                begin
                    req_item <= pending_reqs[0].item;
                    send_gap = pending_reqs[0].gap;
                    pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("result arrived with no item outstanding: %p", rsp_item);
                    error_count++;
                end
                else
                begin
                    gdsc_pkg::rsp_item_t want;
                    want = expected_rsps.pop_front();
                    if (rsp_item.out_serial !== want.out_serial)
                    begin
                        $error("out_serial expected %0d actual %0d",
                               want.out_serial, rsp_item.out_serial);
                        error_count++;
                    end
                    if (rsp_item.out_day !== want.out_day)
                    begin
                        $error("out_day expected %0d actual %0d",
                               want.out_day, rsp_item.out_day);
                        error_count++;
                    end
                    if (rsp_item.out_month !== want.out_month)
                    begin
                        $error("out_month expected %0d actual %0d",
                               want.out_month, rsp_item.out_month);
                        error_count++;
                    end
                    if (rsp_item.out_year !== want.out_year)
                    begin
                        $error("out_year expected %0d actual %0d",
                               want.out_year, rsp_item.out_year);
                        error_count++;
                    end
                end
                rsp_count++;
                stall_left = ((rsp_count / 40) % 4 == 2) ? 0 : $urandom_range(0, 7);
            end
            else if (rsp_valid && stall_left != 0)
            begin
                stall_left--;
            end
            rsp_stall <= (stall_left != 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int unsigned         pick;
        int unsigned         yr;
        int                  s;
        gdsc_pkg::req_item_t it;

        queue_item(encode_req(1, 1, 1601), 1'b0);
        queue_item(encode_req(31, 12, 9999), 1'b0);
        queue_item(encode_req(29, 2, 2000), 1'b0);
        queue_item(encode_req(29, 2, 1900), 1'b0);
        queue_item(encode_req(1, 3, 2400), 1'b0);
        queue_item(encode_req(0, 1, 1601), 1'b0);
        queue_item(encode_req(31, 2, 2023), 1'b0);
        queue_item(encode_req(31, 12, 1700), 1'b0);
        queue_item(encode_req(1, 1, 1600), 1'b0);
        queue_item(encode_req(1, 1, 10000), 1'b0);
        queue_item(encode_req(15, 6, 16383), 1'b0);
        queue_item(encode_req(15, 6, 0), 1'b0);
        queue_item(encode_req(10, 0, 2000), 1'b0);
        queue_item(encode_req(10, 13, 2000), 1'b0);
        queue_item(encode_req(10, 15, 2000), 1'b0);
        queue_item(decode_req(0), 1'b0);
        queue_item(decode_req(1), 1'b0);
        queue_item(decode_req(365), 1'b0);
        queue_item(decode_req(366), 1'b0);
        queue_item(decode_req(146097), 1'b0);
        queue_item(decode_req(146098), 1'b0);
        queue_item(decode_req(serial_of(29, 2, 2000)), 1'b0);
        queue_item(decode_req(serial_of(31, 12, 2000)), 1'b0);
        queue_item(decode_req(LAST_SERIAL), 1'b0);
        queue_item(decode_req(22'h3FFFFF), 1'b0);

        for (int i = 0; i < 430; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                it = encode_req($urandom_range(0, 31), $urandom_range(1, 12),
                                $urandom_range(gdsc_pkg::BASE_YEAR, gdsc_pkg::MAX_YEAR));
            end
            else if (pick < 55)
            begin
                it = decode_req($urandom_range(1, LAST_SERIAL));
            end
            else if (pick < 75)
            begin
                // around a year boundary, where the year estimate needs correcting
                yr = $urandom_range(gdsc_pkg::BASE_YEAR, gdsc_pkg::MAX_YEAR);
                s = serial_of(1, 1, yr) + $urandom_range(0, 4) - 2;
                if (s < 1)
                begin
                    s = 1;
                end
                it = decode_req(s);
            end
            else if (pick < 85)
            begin
                it = encode_req($urandom, $urandom, $urandom);
            end
            else
            begin
                it = ($urandom_range(0, 1) == 0) ? encode_req($urandom, $urandom, $urandom)
                                                 : decode_req($urandom);
            end
            queue_item(it, (i == 0) || (i == 215));
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);

        if (error_count == 0 && expected_rsps.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
design/gdsc_pkg.sv
design/gdsc_mul.sv
design/gdsc_ctrl.sv
design/gregorian_date_serial_converter.sv
dv/gregorian_date_serial_converter_tb.sv
